// ----- rtl/aoe_filter_peak_and_drift_time_defines.svh -----
// assertion macros for the a/e peak and drift time filter
// used by the top level only, no other dependencies
`ifndef AOE_FILTER_PEAK_AND_DRIFT_TIME_DEFINES_SVH
`define AOE_FILTER_PEAK_AND_DRIFT_TIME_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AOE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aoe assertion failed");

// next-cycle implication, disabled during reset
`define AOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aoe assertion failed");

`endif

// ----- rtl/aoe_pkg.sv -----
// shared types and constants for the a/e peak and drift time filter
// no dependencies
package aoe_pkg;

   localparam int WINDOW        = 40;
   localparam int DEPTH         = 2 * WINDOW;
   localparam int MAX_SAMPLES   = 4096;
   localparam int SAMPLE_BITS   = 16;
   localparam int CNT_BITS      = 13;
   localparam int DIFF_BITS     = 23;
   localparam int PEAK_BITS     = 22;
   localparam int AMP_BITS      = 30;
   localparam int THR_BITS      = 16;
   localparam int GAIN_BITS     = 8;
   localparam int COEFF_BITS    = 21;
   localparam int CORR_BITS     = CNT_BITS + COEFF_BITS;
   localparam int FACTOR_BITS   = 33;
   localparam int FLO_BITS      = 16;
   localparam int FHI_BITS      = FACTOR_BITS - FLO_BITS;
   localparam int PROD_BITS     = AMP_BITS + FHI_BITS;
   localparam int SUM_BITS      = AMP_BITS + FACTOR_BITS;
   localparam int QDEPTH        = 4;
   localparam int QPTR_BITS     = 2;
   localparam int QCNT_BITS     = QPTR_BITS + 1;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN        = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_DRIFT_COEFF = 2'd2;

   localparam logic [THR_BITS-1:0]   THRESHOLD_RESET   = 16'd22938;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET        = 8'd50;
   localparam logic [COEFF_BITS-1:0] DRIFT_COEFF_RESET = 21'd85899;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic [AMP_BITS-1:0]  amplitude;
      logic [PEAK_BITS-1:0] peak_raw;
      logic [CNT_BITS-1:0]  drift_time;
      logic                 crossed;
   } rsp_type;

   // one finished waveform waiting for the amplitude stage
   typedef struct packed {
      logic [PEAK_BITS-1:0] peak;
      logic [CNT_BITS-1:0]  drift;
      logic                 crossed;
   } job_type;

   typedef struct packed {
      logic signed [THR_BITS-1:0] threshold;
      logic [GAIN_BITS-1:0]       gain;
      logic [COEFF_BITS-1:0]      drift_coeff;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- rtl/aoe_csr.sv -----
// configuration registers on an apb-style port
// depends on aoe_pkg
module aoe_csr import aoe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [REG_IDX_BITS-1:0] idx;
   logic wr_en;

   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_THRESHOLD:   cfg_in.threshold   = $signed(csr_pwdata[THR_BITS-1:0]);
            REG_GAIN:        cfg_in.gain        = csr_pwdata[GAIN_BITS-1:0];
            REG_DRIFT_COEFF: cfg_in.drift_coeff = csr_pwdata[COEFF_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_THRESHOLD:   csr_prdata = CSR_DATA_BITS'($unsigned(cfg_ff.threshold));
         REG_GAIN:        csr_prdata = CSR_DATA_BITS'(cfg_ff.gain);
         REG_DRIFT_COEFF: csr_prdata = CSR_DATA_BITS'(cfg_ff.drift_coeff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= $signed(THRESHOLD_RESET);
         cfg_ff.gain        <= GAIN_RESET;
         cfg_ff.drift_coeff <= DRIFT_COEFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/aoe_front.sv -----
// per-sample filter: delay line, boxcar difference, peak and drift time
// depends on aoe_pkg; hands one job per waveform to the queue
module aoe_front import aoe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_type      req_data,
   output logic         req_stall,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   output logic         push,
   output job_type      push_data
);

   logic signed [SAMPLE_BITS-1:0] dl_ff [DEPTH];
   logic signed [DIFF_BITS-1:0]   diff_ff, diff_in, diff_next;
   logic [PEAK_BITS-1:0]          peak_ff, peak_in, peak_next;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in, cnt_next;
   logic [CNT_BITS-1:0]           drift_ff, drift_in, drift_next;
   logic                          found_ff, found_in, found_next;

   logic signed [DIFF_BITS-1:0] x_ext, mid_ext, old_ext;
   logic accept, hit;

   // stall only when a job might not fit
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // taps older than the waveform start count as zero
   assign x_ext   = DIFF_BITS'(req_data.sample);
   assign mid_ext = (cnt_ff >= CNT_BITS'(WINDOW)) ? DIFF_BITS'(dl_ff[WINDOW-1]) : '0;
   assign old_ext = (cnt_ff >= CNT_BITS'(DEPTH)) ? DIFF_BITS'(dl_ff[DEPTH-1]) : '0;

   always_comb begin
      diff_next = diff_ff + x_ext - (mid_ext <<< 1) + old_ext;

      peak_next = peak_ff;
      if (cnt_ff >= CNT_BITS'(DEPTH) && diff_next > $signed({1'b0, peak_ff}))
         peak_next = diff_next[PEAK_BITS-1:0];

      hit        = !found_ff && (req_data.sample > cfg.threshold);
      found_next = found_ff || hit;
      drift_next = hit ? cnt_ff : drift_ff;
      cnt_next   = (cnt_ff < CNT_BITS'(MAX_SAMPLES)) ? cnt_ff + 1'b1 : cnt_ff;
   end

   always_comb begin
      diff_in  = diff_ff;
      peak_in  = peak_ff;
      cnt_in   = cnt_ff;
      drift_in = drift_ff;
      found_in = found_ff;
      if (accept) begin
         if (req_data.last) begin
            diff_in  = '0;
            peak_in  = '0;
            cnt_in   = '0;
            drift_in = '0;
            found_in = 1'b0;
         end else begin
            diff_in  = diff_next;
            peak_in  = peak_next;
            cnt_in   = cnt_next;
            drift_in = drift_next;
            found_in = found_next;
         end
      end
   end

   assign push              = accept && req_data.last;
   assign push_data.peak    = peak_next;
   assign push_data.drift   = found_next ? drift_next : cnt_next;
   assign push_data.crossed = found_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff  <= '0;
         peak_ff  <= '0;
         cnt_ff   <= '0;
         drift_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         diff_ff  <= diff_in;
         peak_ff  <= peak_in;
         cnt_ff   <= cnt_in;
         drift_ff <= drift_in;
         found_ff <= found_in;
      end
   end

   // shift line, read only through the count-gated taps
   always_ff @(posedge clock) begin
      if (accept) begin
         dl_ff[0] <= req_data.sample;
         for (int i = 1; i < DEPTH; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

endmodule

// ----- rtl/aoe_jobq.sv -----
// short fifo of finished waveforms between the filter and the amplitude stage
// depends on aoe_pkg
module aoe_jobq import aoe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_data,
   input  logic         pop,
   output job_type      pop_data,
   output q_status_type q_status
);

   job_type mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign q_status.full  = (cnt_ff == QCNT_BITS'(QDEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_data       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- rtl/aoe_back.sv -----
// amplitude stage: peak * gain * (1 - drift * coeff)
// depends on aoe_pkg; one shared 30x17 multiplier for the wide product
module aoe_back import aoe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   input  job_type      pop_data,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         rsp_stall
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_FACT = 3'd2;
   localparam logic [2:0] ST_MLO  = 3'd3;
   localparam logic [2:0] ST_MHI  = 3'd4;
   localparam logic [2:0] ST_SUM  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   job_type job_ff, job_in;
   logic [CORR_BITS-1:0]   corr_ff, corr_in;
   logic [AMP_BITS-1:0]    scaled_ff, scaled_in;
   logic [FACTOR_BITS-1:0] factor_ff, factor_in;
   logic [PROD_BITS-1:0]   plo_ff, plo_in, phi_ff, phi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [FHI_BITS-1:0]  mul_b;
   logic [PROD_BITS-1:0] mul_p;
   logic [SUM_BITS-1:0]  total;

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // factor split in two halves through one multiplier
   assign mul_b = (state_ff == ST_MLO) ? FHI_BITS'(factor_ff[FLO_BITS-1:0])
                                       : factor_ff[FACTOR_BITS-1:FLO_BITS];
   assign mul_p = PROD_BITS'(scaled_ff) * PROD_BITS'(mul_b);
   assign total = ({SUM_BITS'(phi_ff)} << FLO_BITS) + SUM_BITS'(plo_ff);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      corr_in      = corr_ff;
      scaled_in    = scaled_ff;
      factor_in    = factor_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               job_in   = pop_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            corr_in   = CORR_BITS'(job_ff.drift) * CORR_BITS'(cfg.drift_coeff);
            scaled_in = AMP_BITS'(job_ff.peak) * AMP_BITS'(cfg.gain);
            state_in  = ST_FACT;
         end
         ST_FACT: begin
            // correction of 2^32 or more leaves no amplitude
            if (corr_ff[CORR_BITS-1:32] != '0)
               factor_in = '0;
            else
               factor_in = {1'b1, 32'd0} - FACTOR_BITS'(corr_ff[31:0]);
            state_in = ST_MLO;
         end
         ST_MLO: begin
            plo_in   = mul_p;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            phi_in   = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rsp_data_in.amplitude  = total[32 +: AMP_BITS];
            rsp_data_in.peak_raw   = job_ff.peak;
            rsp_data_in.drift_time = job_ff.drift;
            rsp_data_in.crossed    = job_ff.crossed;
            rsp_valid_in           = 1'b1;
            state_in               = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      corr_ff     <= corr_in;
      scaled_ff   <= scaled_in;
      factor_ff   <= factor_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/aoe_filter_peak_and_drift_time.sv -----
// a/e filter: one sample per cycle in, one result per waveform out
// the filter takes a sample every cycle while the job queue (4 deep) has room
// the amplitude stage holds one job at a time through mul, fact, mlo, mhi, sum
// and out, registers rsp_valid in sum and pops the next job only once it is taken
// synchronous active-high reset clears counters, queue, state; config registers to defaults
`include "aoe_filter_peak_and_drift_time_defines.svh"
module aoe_filter_peak_and_drift_time import aoe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  req_type                  req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     rsp_stall,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type      cfg;
   q_status_type q_status;
   logic         push, pop;
   job_type      push_data, pop_data;

   aoe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aoe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .cfg       (cfg),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   aoe_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   aoe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // a pushed job is visible in the queue on the next cycle
   `AOE_ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty)
   // a taken result is never followed directly by another
   `AOE_ASSERT_NEXT(a_no_back_to_back, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
   // drift correction only shrinks the scaled peak
   `AOE_ASSERT_NOW(a_amp_bound, clock, reset, rsp_valid,
      rsp_data.amplitude <= (AMP_BITS'(rsp_data.peak_raw) * AMP_BITS'(cfg.gain)))
   // without a crossing the drift time is the sample count, never zero
   `AOE_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid && !rsp_data.crossed,
      rsp_data.drift_time != '0)

endmodule
